// ===== src/fla_pkg.sv =====
package fla_pkg;

	localparam int HEAP_UNITS = 4096;
	localparam int UNIT_BYTES = 16;
	localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
	localparam int ADDR_W     = $clog2(HEAP_UNITS);
	localparam int SIZE_W     = 32;
	localparam int BYTES_W    = 20;
	localparam int UNITS_W    = BYTES_W - UNIT_SHIFT + 1;
	localparam int CNT_W      = ADDR_W + 1;
	localparam int STAT_W     = 2;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_ZERO    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic              link_we;
		logic [ADDR_W-1:0] link_waddr;
		logic [ADDR_W-1:0] link_wdata;
		logic [ADDR_W-1:0] link_raddr;
		logic              size_we;
		logic [ADDR_W-1:0] size_waddr;
		logic [SIZE_W-1:0] size_wdata;
		logic [ADDR_W-1:0] size_raddr;
	} store_req_t;

	typedef enum logic [13:0] {
		S_CLEAR   = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_A_LINK  = 14'b00000000000100,
		S_A_RD    = 14'b00000000001000,
		S_A_CHK   = 14'b00000000010000,
		S_A_SPLIT = 14'b00000000100000,
		S_R_RD    = 14'b00000001000000,
		S_R_CHK   = 14'b00000010000000,
		S_R_RD_BP = 14'b00000100000000,
		S_R_RD_Q  = 14'b00001000000000,
		S_R_RD_P  = 14'b00010000000000,
		S_R_WR_BP = 14'b00100000000000,
		S_R_WR_P  = 14'b01000000000000,
		S_DONE    = 14'b10000000000000
	} state_t;

endpackage

// ===== src/fla_store.sv =====
module fla_store (
	input  logic                       clk,
	input  fla_pkg::store_req_t        req,
	output logic [fla_pkg::ADDR_W-1:0] link_rd_q,
	output logic [fla_pkg::SIZE_W-1:0] size_rd_q
);
	import fla_pkg::*;

	logic [ADDR_W-1:0] link_mem [HEAP_UNITS];
	logic [SIZE_W-1:0] size_mem [HEAP_UNITS];

	always_ff @(posedge clk) begin
		if (req.link_we) begin
			link_mem[req.link_waddr] <= req.link_wdata;
		end
		link_rd_q <= link_mem[req.link_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.size_we) begin
			size_mem[req.size_waddr] <= req.size_wdata;
		end
		size_rd_q <= size_mem[req.size_raddr];
	end

endmodule

// ===== src/free_list_heap_allocator_unit.sv =====
// next-fit free-list heap allocator over a pool of 4096 units of 16 bytes
// input channel s_axis: tuser carries the operation (0 allocate, 1 release),
// tdata carries the request size in bytes and the payload address to release
// output channel m_axis: one transaction per input, payload unit address and
// status (0 ok, 1 zero-size request, 2 no space)
// one input is worked on at a time; s_axis_tready is high only when idle
// an allocate reads the rover link, then checks one free-list block at a time,
// a split adding a header write; a release walks the list to the block's slot,
// then reads sizes, links and merges; a null or zero-size request goes straight
// to the result; the walk is bounded at 4097 blocks
// the pace is set by the single read port on the link and size memories
// after reset a clearing pass initialises both memories,
// with s_axis_tready held low
// the result sits in an output register; a new input is taken while it waits,
// and a later result holds in the sequencer until m_axis_tready frees the slot
module free_list_heap_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // request_bytes[19:0], release_address[31:20]
	input  logic [0:0]  s_axis_tuser,   // operation[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // payload_address[11:0], status[13:12], zero[15:14]
);
	import fla_pkg::*;

	state_t              state_q;
	logic [ADDR_W-1:0]   rov_q, prev_q, p_q, q_q, bp_q, clr_q;
	logic [UNITS_W-1:0]  units_q;
	logic [CNT_W-1:0]    n_q;
	logic [SIZE_W-1:0]   sbp_q, sq_q, sp_q, nbs_q;
	logic [ADDR_W-1:0]   lq_q, nbl_q;
	logic [ADDR_W-1:0]   res_addr_q, out_addr_q;
	logic [STAT_W-1:0]   res_st_q, out_st_q;
	logic                out_valid_q;

	store_req_t          req;
	logic [ADDR_W-1:0]   link_rd;
	logic [SIZE_W-1:0]   size_rd;

	logic                in_acc;
	logic                op;
	logic [BYTES_W-1:0]  req_bytes;
	logic [ADDR_W-1:0]   rel_addr;
	logic [UNITS_W-1:0]  units_calc;
	logic [SIZE_W-1:0]   units_ext, new_sz;
	logic                fit, exact, found, last_iter;
	logic                join_hi, join_lo;
	logic [SIZE_W-1:0]   nbs_calc;
	logic [ADDR_W-1:0]   nbl_calc;

	fla_store u_store (
		.clk       (clk),
		.req       (req),
		.link_rd_q (link_rd),
		.size_rd_q (size_rd)
	);

	assign op        = s_axis_tuser[0];
	assign req_bytes = s_axis_tdata[BYTES_W-1:0];
	assign rel_addr  = s_axis_tdata[BYTES_W+ADDR_W-1:BYTES_W];
	assign in_acc    = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_st_q, out_addr_q};

	// ceil(bytes / unit) plus one header unit
	assign units_calc = UNITS_W'((({1'b0, req_bytes} + (BYTES_W+1)'(UNIT_BYTES - 1))
		>> UNIT_SHIFT) + 1'b1);
	assign units_ext  = SIZE_W'(units_q);
	assign fit        = (size_rd >= units_ext);
	assign exact      = (size_rd == units_ext);
	assign new_sz     = size_rd - units_ext;
	assign last_iter  = (n_q == CNT_W'(HEAP_UNITS));

	assign found = ((bp_q > p_q) && (bp_q < link_rd)) ||
		((p_q >= link_rd) && ((bp_q > p_q) || (bp_q < link_rd)));

	assign join_hi  = ((SIZE_W+1)'(bp_q) + (SIZE_W+1)'(sbp_q)) == (SIZE_W+1)'(q_q);
	assign nbs_calc = join_hi ? (sbp_q + sq_q) : sbp_q;
	assign nbl_calc = join_hi ? lq_q : q_q;
	assign join_lo  = ((SIZE_W+1)'(p_q) + (SIZE_W+1)'(sp_q)) == (SIZE_W+1)'(bp_q);

	always_comb begin
		req = '0;
		req.link_raddr = p_q;
		req.size_raddr = p_q;
		unique case (state_q)
			S_CLEAR: begin
				req.link_we    = 1'b1;
				req.link_waddr = clr_q;
				req.link_wdata = (clr_q == '0) ? ADDR_W'(1) : '0;
				req.size_we    = 1'b1;
				req.size_waddr = clr_q;
				req.size_wdata = (clr_q == ADDR_W'(1)) ? SIZE_W'(HEAP_UNITS - 1) : '0;
			end
			S_IDLE: begin
				req.link_raddr = rov_q;
			end
			S_A_CHK: begin
				if (fit && exact) begin
					req.link_we    = 1'b1;
					req.link_waddr = prev_q;
					req.link_wdata = link_rd;
				end else if (fit) begin
					req.size_we    = 1'b1;
					req.size_waddr = p_q;
					req.size_wdata = new_sz;
				end
			end
			S_A_SPLIT: begin
				req.size_we    = 1'b1;
				req.size_waddr = p_q;
				req.size_wdata = units_ext;
			end
			S_R_RD_BP: begin
				req.size_raddr = bp_q;
			end
			S_R_RD_Q: begin
				req.size_raddr = q_q;
				req.link_raddr = q_q;
			end
			S_R_WR_BP: begin
				req.size_we    = 1'b1;
				req.size_waddr = bp_q;
				req.size_wdata = nbs_calc;
				req.link_we    = 1'b1;
				req.link_waddr = bp_q;
				req.link_wdata = nbl_calc;
			end
			S_R_WR_P: begin
				req.link_we    = 1'b1;
				req.link_waddr = p_q;
				if (join_lo) begin
					req.size_we    = 1'b1;
					req.size_waddr = p_q;
					req.size_wdata = sp_q + nbs_q;
					req.link_wdata = nbl_q;
				end else begin
					req.link_wdata = bp_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rov_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(HEAP_UNITS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						n_q <= '0;
						if (op == OP_ALLOC) begin
							if (req_bytes == '0) begin
								res_addr_q <= '0;
								res_st_q   <= ST_ZERO;
								state_q    <= S_DONE;
							end else begin
								units_q <= units_calc;
								prev_q  <= rov_q;
								state_q <= S_A_LINK;
							end
						end else begin
							res_addr_q <= '0;
							res_st_q   <= ST_OK;
							if (rel_addr == '0 || rel_addr == ADDR_W'(1)) begin
								state_q <= S_DONE;
							end else begin
								bp_q    <= rel_addr - 1'b1;
								p_q     <= rov_q;
								state_q <= S_R_RD;
							end
						end
					end
				end
				S_A_LINK: begin
					p_q     <= link_rd;
					state_q <= S_A_RD;
				end
				S_A_RD: begin
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (fit) begin
						rov_q <= prev_q;
						if (exact) begin
							res_addr_q <= p_q + 1'b1;
							res_st_q   <= ST_OK;
							state_q    <= S_DONE;
						end else begin
							p_q     <= p_q + new_sz[ADDR_W-1:0];
							state_q <= S_A_SPLIT;
						end
					end else if (p_q == rov_q || last_iter) begin
						res_addr_q <= '0;
						res_st_q   <= ST_NOSPACE;
						state_q    <= S_DONE;
					end else begin
						prev_q  <= p_q;
						p_q     <= link_rd;
						n_q     <= n_q + 1'b1;
						state_q <= S_A_RD;
					end
				end
				S_A_SPLIT: begin
					res_addr_q <= p_q + 1'b1;
					res_st_q   <= ST_OK;
					state_q    <= S_DONE;
				end
				S_R_RD: begin
					state_q <= S_R_CHK;
				end
				S_R_CHK: begin
					if (found) begin
						q_q     <= link_rd;
						state_q <= S_R_RD_BP;
					end else if (last_iter) begin
						state_q <= S_DONE;
					end else begin
						p_q     <= link_rd;
						n_q     <= n_q + 1'b1;
						state_q <= S_R_RD;
					end
				end
				S_R_RD_BP: begin
					state_q <= S_R_RD_Q;
				end
				S_R_RD_Q: begin
					sbp_q   <= size_rd;
					state_q <= S_R_RD_P;
				end
				S_R_RD_P: begin
					sq_q    <= size_rd;
					lq_q    <= link_rd;
					state_q <= S_R_WR_BP;
				end
				S_R_WR_BP: begin
					sp_q    <= size_rd;
					nbs_q   <= nbs_calc;
					nbl_q   <= nbl_calc;
					state_q <= S_R_WR_P;
				end
				S_R_WR_P: begin
					rov_q   <= p_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_addr_q  <= res_addr_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
